// File: rtl/rbfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfb_pkg
// Widths, codes and constants shared by the rule-based feature bias block.
// ----------------------------------------------------------------------------
package rbfb_pkg;

  localparam int CoordW    = 32;  // rectangle coordinates
  localparam int WireW     = 24;  // drawn wire width
  localparam int ResW      = 16;  // resolution limit register
  localparam int BiasW     = 24;  // reported bias
  localparam int MaxW      = 23;  // largest cell bias
  localparam int SumW      = 44;  // running bias sum, also divider dividend width
  localparam int RuleNumW  = 36;  // widest bias-rule numerator
  localparam int DivStepW  = 2;   // quotient bits resolved per divider cycle
  localparam int CntW      = 5;   // divider cycle counter
  localparam int MidDvsW   = 19;  // 5 * resolution limit

  localparam int ResBaseNm  = 104; // reset limit in whole nm
  localparam int LowBandDiv = 10;  // 0.3 f  = 3 f / 10
  localparam int RuleIter   = RuleNumW / DivStepW;
  localparam int AvgIter    = SumW / DivStepW;

  typedef enum logic [2:0] {
    FIX_NONE   = 3'd0,
    FIX_BIAS   = 3'd1,
    FIX_SERIF  = 3'd2,
    FIX_HAMMER = 3'd3,
    FIX_WIRE   = 3'd4
  } fix_e;

  // divider jobs, in the order they run
  typedef enum logic [1:0] {
    OP_REP,
    OP_WIDTH,
    OP_HEIGHT,
    OP_AVG
  } op_e;

endpackage

// File: rtl/rule_based_feature_bias.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_based_feature_bias
// Per-feature lithography bias by rule, with run statistics and run average.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+-----------
//  in       | in_valid_i / in_ready_o, feature fields   | input beat
//  out      | out_valid_o / out_ready_i, result fields  | output beat
//  cfg      | cfg_we_i, cfg_wdata_i (resolution limit)  | write only
//
//  A feature with no correction goes from capture through evaluation and
//  update to the output register. A corrected feature sends each of its three
//  bias rules that lands outside the zero band through the one shared radix-4
//  shift-subtract divider, and a last beat with corrections also divides for
//  the average; all rule divides and the average go through that divider.
//  Reset clears the counters, the sum, the largest bias and the limit (to
//  104 nm). A finished result waits in the output register; the next item may
//  be taken meanwhile but holds in its final cycle until that register frees.
// ----------------------------------------------------------------------------
module rule_based_feature_bias
  import rbfb_pkg::*;
#(
  parameter int COUNT_BITS = 20,
  parameter int FRAC_BITS  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [ResW-1:0]              cfg_wdata_i,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic                         placed_i,
  input  logic signed [CoordW-1:0]     left_i,
  input  logic signed [CoordW-1:0]     bottom_i,
  input  logic signed [CoordW-1:0]     right_i,
  input  logic signed [CoordW-1:0]     top_i,
  input  logic [WireW-1:0]             wire_width_i,
  input  logic                         last_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         corrected_o,
  output logic [2:0]                   fix_type_o,
  output logic signed [CoordW-1:0]     out_left_o,
  output logic signed [CoordW-1:0]     out_bottom_o,
  output logic signed [CoordW-1:0]     out_right_o,
  output logic signed [CoordW-1:0]     out_top_o,
  output logic signed [BiasW-1:0]      bias_o,
  output logic [COUNT_BITS-1:0]        analysed_total_o,
  output logic [COUNT_BITS-1:0]        applied_total_o,
  output logic [MaxW-1:0]              largest_bias_o,
  output logic signed [BiasW-1:0]      average_bias_o,
  output logic                         run_end_o
);

  localparam int DivW = (COUNT_BITS > MidDvsW) ? COUNT_BITS : MidDvsW;
  localparam logic [ResW-1:0] ResReset = ResW'(ResBaseNm << FRAC_BITS);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PREP,
    S_DIV,
    S_POST,
    S_UPD,
    S_FIN
  } state_e;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [CoordW-1:0] sat32(input logic signed [CoordW+1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed({2'b00, 1'b0, {(CoordW-1){1'b1}}})) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < $signed({2'b11, 1'b1, {(CoordW-1){1'b0}}})) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic logic [BiasW-1:0] sat24(input logic signed [CoordW-1:0] v);
    logic [BiasW-1:0] r;
    if (v > $signed({{(CoordW-BiasW+1){1'b0}}, {(BiasW-1){1'b1}}})) begin
      r = {1'b0, {(BiasW-1){1'b1}}};
    end else if (v < $signed({{(CoordW-BiasW+1){1'b1}}, {(BiasW-1){1'b0}}})) begin
      r = {1'b1, {(BiasW-1){1'b0}}};
    end else begin
      r = v[BiasW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SumW-1:0] sat44(input logic signed [SumW:0] v);
    logic [SumW-1:0] r;
    if (v > $signed({2'b00, {(SumW-1){1'b1}}})) begin
      r = {1'b0, {(SumW-1){1'b1}}};
    end else if (v < $signed({2'b11, {(SumW-1){1'b0}}})) begin
      r = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
    return (c == CountMax) ? c : c + COUNT_BITS'(1);
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e                    state_q;
  op_e                       op_q;
  logic [ResW-1:0]           res_cfg_q;

  logic                      kind_q, placed_q, last_q;
  logic signed [CoordW-1:0]  l_q, b_q, r_q, t_q;
  logic [WireW-1:0]          ww_q;
  logic                      corr_q, counted_q;
  fix_e                      fix_q;

  logic signed [CoordW-1:0]  rep_q, bw_q, bh_q;
  logic [BiasW-1:0]          avg_q;

  logic [DivW-1:0]           rem_q, dvs_q;
  logic [SumW-1:0]           quo_q;
  logic                      neg_q;
  logic [CntW-1:0]           cnt_q;

  logic [COUNT_BITS-1:0]     analysed_q, applied_q;
  logic [SumW-1:0]           sum_q;
  logic [MaxW-1:0]           max_q;

  logic                      out_valid_q, corrected_q, run_end_q;
  fix_e                      fix_type_q;
  logic [CoordW-1:0]         ol_q, ob_q, or_q, ot_q;
  logic [BiasW-1:0]          bias_q, average_q;
  logic [COUNT_BITS-1:0]     analysed_out_q, applied_out_q;
  logic [MaxW-1:0]           largest_q;

  // --------------------------------------------------------------------------
  // limit and derived thresholds
  // --------------------------------------------------------------------------
  logic [ResW-1:0]           res_eff;
  logic [ResW:0]             res2;
  logic [ResW+1:0]           res3;
  logic signed [34:0]        r_x, r2_x, r3_x;

  assign res_eff = (res_cfg_q == '0) ? ResW'(1) : res_cfg_q;
  assign res2    = {res_eff, 1'b0};
  assign res3    = {1'b0, res2} + {2'b00, res_eff};
  assign r_x     = $signed({19'b0, res_eff});
  assign r2_x    = $signed({18'b0, res2});
  assign r3_x    = $signed({17'b0, res3});

  // --------------------------------------------------------------------------
  // feature dimensions and classification
  // --------------------------------------------------------------------------
  logic signed [CoordW:0]    w_raw, h_raw;
  logic signed [34:0]        w_x, h_x;
  logic                      cell_corr, wire_corr;
  fix_e                      cell_fix;

  assign w_raw = $signed({r_q[CoordW-1], r_q}) - $signed({l_q[CoordW-1], l_q});
  assign h_raw = $signed({t_q[CoordW-1], t_q}) - $signed({b_q[CoordW-1], b_q});
  assign w_x   = $signed({{2{w_raw[CoordW]}}, w_raw});
  assign h_x   = $signed({{2{h_raw[CoordW]}}, h_raw});

  assign cell_corr = placed_q && ((w_x < r2_x) || (h_x < r2_x));
  assign wire_corr = {1'b0, ww_q} < {{(WireW-ResW){1'b0}}, res2};

  always_comb begin
    priority if (w_x < r_x) begin
      cell_fix = FIX_HAMMER;
    end else if ((w_x <<< 1) < r3_x) begin
      cell_fix = FIX_SERIF;
    end else begin
      cell_fix = FIX_BIAS;
    end
  end

  // --------------------------------------------------------------------------
  // divider operand preparation
  // --------------------------------------------------------------------------
  logic signed [34:0]        f_x;
  logic                      zero_band, low_band, over_r;
  logic [33:0]               f_abs;
  logic [RuleNumW-1:0]       low_num, rule_num;
  logic [17:0]               f_m, diff18;
  logic [15:0]               diff;
  logic [33:0]               mid_num;
  logic [MidDvsW-1:0]        mid_dvs;
  logic [SumW-1:0]           sum_abs;

  always_comb begin
    unique case (op_q)
      OP_REP:    f_x = kind_q ? $signed({11'b0, ww_q}) : ((w_x < h_x) ? w_x : h_x);
      OP_WIDTH:  f_x = w_x;
      OP_HEIGHT: f_x = h_x;
      default:   f_x = '0;
    endcase
  end

  assign zero_band = f_x > r2_x;
  assign low_band  = (f_x <<< 1) < r_x;
  assign over_r    = f_x > r_x;
  assign f_abs     = f_x[34] ? 34'(-f_x) : f_x[33:0];
  assign low_num   = {2'b00, f_abs} + {1'b0, f_abs, 1'b0};
  // middle band: R/2 <= f <= 2R, so f fits 18 bits and |R - f| fits 16
  assign f_m       = f_x[17:0];
  assign diff18    = over_r ? (f_m - {2'b00, res_eff}) : ({2'b00, res_eff} - f_m);
  assign diff      = diff18[15:0];
  assign mid_num   = {16'b0, f_m} * {18'b0, diff};
  assign mid_dvs   = {1'b0, res_eff, 2'b00} + {3'b000, res_eff};
  assign rule_num  = low_band ? low_num : {2'b00, mid_num};
  assign sum_abs   = sum_q[SumW-1] ? SumW'(-$signed(sum_q)) : sum_q;

  // --------------------------------------------------------------------------
  // shared restoring divider, DivStepW quotient bits per cycle
  // --------------------------------------------------------------------------
  logic [DivW-1:0]           rem_d;
  logic [SumW-1:0]           quo_d;

  always_comb begin
    logic [DivW:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DivStepW; i++) begin
      trial = {rem_d, quo_d[SumW-1]};
      quo_d = {quo_d[SumW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DivW-1:0];
    end
  end

  // quotient post-processing
  logic signed [CoordW-1:0]  rule_val;
  logic [BiasW-1:0]          avg_val;

  assign rule_val = neg_q ? -$signed(quo_q[CoordW-1:0]) : $signed(quo_q[CoordW-1:0]);

  always_comb begin
    if (neg_q) begin
      if (quo_q > SumW'({1'b1, {(BiasW-1){1'b0}}})) begin
        avg_val = {1'b1, {(BiasW-1){1'b0}}};
      end else begin
        avg_val = -quo_q[BiasW-1:0];
      end
    end else begin
      if (quo_q > SumW'({(BiasW-1){1'b1}})) begin
        avg_val = {1'b0, {(BiasW-1){1'b1}}};
      end else begin
        avg_val = quo_q[BiasW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // result and statistics update
  // --------------------------------------------------------------------------
  logic signed [CoordW-1:0]  hw, hh;
  logic [CoordW-1:0]         nl, nb, nr, nt;
  logic [BiasW-1:0]          rep_sat;
  logic [SumW-1:0]           sum_d;
  logic [COUNT_BITS-1:0]     applied_d, analysed_d;
  logic [MaxW-1:0]           max_d;

  assign hw  = bw_q >>> 1;
  assign hh  = bh_q >>> 1;
  assign nl  = sat32($signed({{2{l_q[CoordW-1]}}, l_q}) - $signed({{2{hw[CoordW-1]}}, hw}));
  assign nb  = sat32($signed({{2{b_q[CoordW-1]}}, b_q}) - $signed({{2{hh[CoordW-1]}}, hh}));
  assign nr  = sat32($signed({{2{r_q[CoordW-1]}}, r_q}) + $signed({{2{hw[CoordW-1]}}, hw}));
  assign nt  = sat32($signed({{2{t_q[CoordW-1]}}, t_q}) + $signed({{2{hh[CoordW-1]}}, hh}));
  assign rep_sat = sat24(rep_q);
  assign sum_d   = sat44($signed({sum_q[SumW-1], sum_q})
                       + $signed({{(SumW-BiasW+1){rep_sat[BiasW-1]}}, rep_sat}));
  assign applied_d  = corr_q ? cnt_inc(applied_q) : applied_q;
  assign analysed_d = counted_q ? cnt_inc(analysed_q) : analysed_q;
  assign max_d = (corr_q && !kind_q && ($signed(rep_sat) > $signed({1'b0, max_q})))
               ? rep_sat[MaxW-1:0] : max_q;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cfg_q <= ResReset;
    end else if (cfg_we_i) begin
      res_cfg_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_REP;
      out_valid_q <= 1'b0;
      analysed_q  <= '0;
      applied_q   <= '0;
      sum_q       <= '0;
      max_q       <= '0;
    end else begin
      // S_FIN drives the valid flag itself when it loads a new beat
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= kind_i;
            placed_q <= placed_i;
            l_q      <= left_i;
            b_q      <= bottom_i;
            r_q      <= right_i;
            t_q      <= top_i;
            ww_q     <= wire_width_i;
            last_q   <= last_i;
            state_q  <= S_EVAL;
          end
        end

        S_EVAL: begin
          op_q <= OP_REP;
          if (kind_q) begin
            counted_q <= 1'b1;
            corr_q    <= wire_corr;
            fix_q     <= wire_corr ? FIX_WIRE : FIX_NONE;
            // wires are normalized before biasing
            if (wire_corr && (r_q < l_q)) begin
              l_q <= r_q;
              r_q <= l_q;
            end
            if (wire_corr && (t_q < b_q)) begin
              b_q <= t_q;
              t_q <= b_q;
            end
            state_q <= wire_corr ? S_PREP : S_UPD;
          end else begin
            counted_q <= placed_q;
            corr_q    <= cell_corr;
            fix_q     <= cell_corr ? cell_fix : FIX_NONE;
            state_q   <= cell_corr ? S_PREP : S_UPD;
          end
        end

        S_PREP: begin
          rem_q <= '0;
          if (op_q == OP_AVG) begin
            quo_q   <= sum_abs;
            dvs_q   <= DivW'(applied_q);
            neg_q   <= sum_q[SumW-1];
            cnt_q   <= CntW'(AvgIter);
            state_q <= S_DIV;
          end else if (zero_band) begin
            // beyond 2R the rule gives no bias, no divide needed
            unique case (op_q)
              OP_REP:    begin rep_q <= '0; op_q <= OP_WIDTH;  end
              OP_WIDTH:  begin bw_q  <= '0; op_q <= OP_HEIGHT; end
              default:   begin bh_q  <= '0; state_q <= S_UPD;  end
            endcase
          end else begin
            quo_q   <= {rule_num, {(SumW-RuleNumW){1'b0}}};
            dvs_q   <= low_band ? DivW'(LowBandDiv) : DivW'(mid_dvs);
            neg_q   <= low_band ? f_x[34] : over_r;
            cnt_q   <= CntW'(RuleIter);
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= S_POST;
          end
        end

        S_POST: begin
          unique case (op_q)
            OP_REP: begin
              rep_q   <= rule_val;
              op_q    <= OP_WIDTH;
              state_q <= S_PREP;
            end
            OP_WIDTH: begin
              bw_q    <= rule_val;
              op_q    <= OP_HEIGHT;
              state_q <= S_PREP;
            end
            OP_HEIGHT: begin
              bh_q    <= rule_val;
              state_q <= S_UPD;
            end
            OP_AVG: begin
              avg_q   <= avg_val;
              state_q <= S_FIN;
            end
            default: state_q <= S_FIN;
          endcase
        end

        S_UPD: begin
          avg_q      <= '0;
          analysed_q <= analysed_d;
          applied_q  <= applied_d;
          max_q      <= max_d;
          if (corr_q) begin
            l_q   <= nl;
            b_q   <= nb;
            r_q   <= nr;
            t_q   <= nt;
            rep_q <= $signed({{(CoordW-BiasW){rep_sat[BiasW-1]}}, rep_sat});
            sum_q <= sum_d;
          end else begin
            rep_q <= '0;
          end
          if (last_q && (applied_d != '0)) begin
            op_q    <= OP_AVG;
            state_q <= S_PREP;
          end else begin
            state_q <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            corrected_q    <= corr_q;
            fix_type_q     <= fix_q;
            ol_q           <= l_q;
            ob_q           <= b_q;
            or_q           <= r_q;
            ot_q           <= t_q;
            bias_q         <= rep_q[BiasW-1:0];
            analysed_out_q <= analysed_q;
            applied_out_q  <= applied_q;
            largest_q      <= max_q;
            average_q      <= avg_q;
            run_end_q      <= last_q;
            if (last_q) begin
              analysed_q <= '0;
              applied_q  <= '0;
              sum_q      <= '0;
              max_q      <= '0;
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign corrected_o      = corrected_q;
  assign fix_type_o       = fix_type_q;
  assign out_left_o       = ol_q;
  assign out_bottom_o     = ob_q;
  assign out_right_o      = or_q;
  assign out_top_o        = ot_q;
  assign bias_o           = bias_q;
  assign analysed_total_o = analysed_out_q;
  assign applied_total_o  = applied_out_q;
  assign largest_bias_o   = largest_q;
  assign average_bias_o   = average_q;
  assign run_end_o        = run_end_q;

endmodule

// File: tb/rule_based_feature_bias_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_based_feature_bias_tb
// Self-checking bench for the rule-based feature bias block. A queue-fed
// driver sends cell and wire features with random gaps, and a monitor
// compares every result beat against an in-bench bias predictor. The run
// steps through several resolution limits, including the extremes, and the
// result side stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module rule_based_feature_bias_tb;
  import rbfb_pkg::*;

  localparam int     CountBits  = 20;
  localparam int     FracBits   = 4;
  localparam int     Phases     = 10;
  localparam int     PhaseItems = 163;
  localparam int     HoldAt     = 60;   // results seen before the long stall
  localparam int     HoldCycles = 400;
  localparam longint MaxC       = (longint'(1) << 31) - 1;
  localparam longint MinC       = -(longint'(1) << 31);
  localparam longint MaxB       = (longint'(1) << (BiasW - 1)) - 1;
  localparam longint MinB       = -(longint'(1) << (BiasW - 1));
  localparam longint MaxSum     = (longint'(1) << (SumW - 1)) - 1;
  localparam longint MinSum     = -(longint'(1) << (SumW - 1));
  localparam longint CountMax   = (longint'(1) << CountBits) - 1;

  typedef struct packed {
    logic                     kind;
    logic                     placed;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] bottom;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] top;
    logic [WireW-1:0]         wire_width;
    logic                     last;
  } feature_t;

  typedef struct packed {
    logic                     corrected;
    fix_e                     fix;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] bottom;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] top;
    logic signed [BiasW-1:0]  bias;
    logic [CountBits-1:0]     analysed;
    logic [CountBits-1:0]     applied;
    logic [MaxW-1:0]          largest;
    logic signed [BiasW-1:0]  average;
    logic                     run_end;
  } bias_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ResW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  feature_t feat_d = '0;

  logic                     in_ready_o;
  logic                     out_valid_o;
  logic                     corrected_o;
  logic [2:0]               fix_type_o;
  logic signed [CoordW-1:0] out_left_o;
  logic signed [CoordW-1:0] out_bottom_o;
  logic signed [CoordW-1:0] out_right_o;
  logic signed [CoordW-1:0] out_top_o;
  logic signed [BiasW-1:0]  bias_o;
  logic [CountBits-1:0]     analysed_total_o;
  logic [CountBits-1:0]     applied_total_o;
  logic [MaxW-1:0]          largest_bias_o;
  logic signed [BiasW-1:0]  average_bias_o;
  logic                     run_end_o;

  // predictor state, mirrors the block
  logic [ResW-1:0] limit_now = ResW'(ResBaseNm << FracBits);
  longint n_analysed = 0;
  longint n_applied = 0;
  longint sum_bias = 0;
  longint peak_cell_bias = 0;

  feature_t     feature_q[$];
  bias_result_t bias_expected_q[$];

  logic in_beat_q = 1'b0;
  logic out_beat_q = 1'b0;
  logic steady = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   in_gap = 0;
  int   rx_wait = 0;
  int   results_seen = 0;
  int   n_fail = 0;
  int   n_run_ends = 0;
  int   fix_seen[5] = '{default: 0};

  rule_based_feature_bias u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (feat_d.kind),
    .placed_i         (feat_d.placed),
    .left_i           (feat_d.left),
    .bottom_i         (feat_d.bottom),
    .right_i          (feat_d.right),
    .top_i            (feat_d.top),
    .wire_width_i     (feat_d.wire_width),
    .last_i           (feat_d.last),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .corrected_o      (corrected_o),
    .fix_type_o       (fix_type_o),
    .out_left_o       (out_left_o),
    .out_bottom_o     (out_bottom_o),
    .out_right_o      (out_right_o),
    .out_top_o        (out_top_o),
    .bias_o           (bias_o),
    .analysed_total_o (analysed_total_o),
    .applied_total_o  (applied_total_o),
    .largest_bias_o   (largest_bias_o),
    .average_bias_o   (average_bias_o),
    .run_end_o        (run_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint bump(longint c);
    return (c >= CountMax) ? CountMax : c + 1;
  endfunction

  // 0.3f below R/2, zero above 2R, 0.2f(1 - f/R) in between
  function automatic longint band_bias(longint f, longint r);
    if (f > 2 * r) return 0;
    if (2 * f < r) return (f * 3) / 10;
    return (f * (r - f)) / (5 * r);
  endfunction

  function automatic bias_result_t predict_bias(feature_t f);
    bias_result_t o;
    longint res, l, b, r, t, w, h, rep, hw, hh, s;
    logic counted;
    res = (limit_now == 0) ? 1 : longint'(limit_now);
    l = longint'($signed(f.left));
    b = longint'($signed(f.bottom));
    r = longint'($signed(f.right));
    t = longint'($signed(f.top));
    rep = 0;
    counted = 1'b0;
    o = '0;
    o.fix = FIX_NONE;
    o.left = f.left;
    o.bottom = f.bottom;
    o.right = f.right;
    o.top = f.top;
    if (!f.kind) begin
      if (f.placed) begin
        w = r - l;
        h = t - b;
        counted = 1'b1;
        if (w < 2 * res || h < 2 * res) begin
          o.corrected = 1'b1;
          if (w < res) o.fix = FIX_HAMMER;
          else if (2 * w < 3 * res) o.fix = FIX_SERIF;
          else o.fix = FIX_BIAS;
          rep = band_bias((w < h) ? w : h, res);
        end
      end
    end else begin
      counted = 1'b1;
      if (longint'(f.wire_width) < 2 * res) begin
        o.corrected = 1'b1;
        o.fix = FIX_WIRE;
        if (r < l) begin
          s = l; l = r; r = s;
        end
        if (t < b) begin
          s = b; b = t; t = s;
        end
        rep = band_bias(longint'(f.wire_width), res);
      end
    end
    if (o.corrected) begin
      hw = band_bias(r - l, res) >>> 1;
      hh = band_bias(t - b, res) >>> 1;
      o.left = CoordW'(sat(l - hw, MinC, MaxC));
      o.bottom = CoordW'(sat(b - hh, MinC, MaxC));
      o.right = CoordW'(sat(r + hw, MinC, MaxC));
      o.top = CoordW'(sat(t + hh, MinC, MaxC));
      rep = sat(rep, MinB, MaxB);
      n_applied = bump(n_applied);
      sum_bias = sat(sum_bias + rep, MinSum, MaxSum);
      if (!f.kind && rep > peak_cell_bias) peak_cell_bias = rep;
    end
    if (counted) n_analysed = bump(n_analysed);
    if (f.last && n_applied > 0) o.average = BiasW'(sat(sum_bias / n_applied, MinB, MaxB));
    o.bias = BiasW'(rep);
    o.analysed = CountBits'(n_analysed);
    o.applied = CountBits'(n_applied);
    o.largest = MaxW'(peak_cell_bias);
    o.run_end = f.last;
    fix_seen[int'(o.fix)]++;
    if (f.last) begin
      n_analysed = 0;
      n_applied = 0;
      sum_bias = 0;
      peak_cell_bias = 0;
      n_run_ends++;
    end
    return o;
  endfunction

  function automatic int draw_idle();
    if (steady) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 17));
  endfunction

  // sizes cluster around the limit's band edges, with some negative and huge
  function automatic longint pick_size(longint r);
    longint edges[8];
    edges = '{r / 2, (r + 1) / 2, r - 1, r, (3 * r) / 2, (3 * r + 1) / 2, 2 * r - 1, 2 * r};
    unique case ($urandom_range(0, 9))
      0, 1:    return longint'($urandom_range(0, r / 2));
      2, 3, 4: return longint'($urandom_range(r / 2, 2 * r));
      5:       return longint'($urandom_range(2 * r, 4 * r));
      6, 7:    return edges[3'($urandom_range(0, 7))];
      8:       return -longint'($urandom_range(1, 2 * r));
      default: return longint'($urandom);
    endcase
  endfunction

  function automatic longint pick_origin();
    unique case ($urandom_range(0, 5))
      0:       return longint'(int'($urandom));
      1:       return MaxC - longint'($urandom_range(0, 300000));
      2:       return MinC + longint'($urandom_range(0, 300000));
      default: return longint'($urandom_range(0, 4000000)) - 2000000;
    endcase
  endfunction

  function automatic feature_t random_feature(longint r);
    feature_t f;
    longint x0, y0, w, h, ww;
    x0 = pick_origin();
    y0 = pick_origin();
    w = pick_size(r);
    h = pick_size(r);
    f.kind = ($urandom_range(0, 2) == 0);
    f.placed = ($urandom_range(0, 9) != 0);
    if (f.kind && $urandom_range(0, 3) == 0) begin
      x0 = x0 + w;
      w = -w;
    end
    f.left = CoordW'(x0);
    f.right = CoordW'(x0 + w);
    f.bottom = CoordW'(y0);
    f.top = CoordW'(y0 + h);
    ww = pick_size(r);
    if ($urandom_range(0, 4) == 0) f.wire_width = WireW'($urandom);
    else f.wire_width = WireW'((ww < 0) ? -ww : ww);
    f.last = ($urandom_range(0, 39) == 0);
    return f;
  endfunction

  task automatic add_cell(input longint x0, y0, x1, y1, input logic placed, last);
    feature_t f;
    f = '0;
    f.placed = placed;
    f.left = CoordW'(x0);
    f.bottom = CoordW'(y0);
    f.right = CoordW'(x1);
    f.top = CoordW'(y1);
    f.wire_width = WireW'($urandom);
    f.last = last;
    feature_q.insert(feature_q.size(), f);
  endtask

  task automatic add_wire(input longint x0, y0, x1, y1, ww, input logic last);
    feature_t f;
    f.kind = 1'b1;
    f.placed = 1'($urandom_range(0, 1));
    f.left = CoordW'(x0);
    f.bottom = CoordW'(y0);
    f.right = CoordW'(x1);
    f.top = CoordW'(y1);
    f.wire_width = WireW'(ww);
    f.last = last;
    feature_q.insert(feature_q.size(), f);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  task automatic wait_drained();
    while (feature_q.size() != 0 || bias_expected_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [ResW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_now = v;
  endtask

  // feature driver: holds a beat until taken, then waits its drawn gap
  always @(negedge clk_i) begin : drive_features
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat_q) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (feature_q.size() > 0) begin
        feat_d <= feature_q.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= draw_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_beat_q) rx_wait = draw_idle();
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (hold_left == 0);
      end
    end
  end

  // one long result-side stall so the block backs up into its input
  always @(negedge clk_i) begin : long_hold
    if (!hold_done && results_seen == HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch_results
    bias_result_t due;
    if (!rst_ni) begin
      in_beat_q <= 1'b0;
      out_beat_q <= 1'b0;
    end else begin
      in_beat_q <= in_valid_i && in_ready_o;
      out_beat_q <= out_valid_o && out_ready_i;
      // compare before pushing so a same-edge input never pairs with this beat
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (bias_expected_q.size() == 0) begin
          $error("result beat with no feature outstanding");
          n_fail++;
        end else begin
          due = bias_expected_q.pop_front();
          check_field("corrected", due.corrected, corrected_o);
          check_field("fix_type", due.fix, fix_type_o);
          check_field("out_left", due.left, out_left_o);
          check_field("out_bottom", due.bottom, out_bottom_o);
          check_field("out_right", due.right, out_right_o);
          check_field("out_top", due.top, out_top_o);
          check_field("bias", due.bias, bias_o);
          check_field("analysed_total", due.analysed, analysed_total_o);
          check_field("applied_total", due.applied, applied_total_o);
          check_field("largest_bias", due.largest, largest_bias_o);
          check_field("average_bias", due.average, average_bias_o);
          check_field("run_end", due.run_end, run_end_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        bias_expected_q.insert(bias_expected_q.size(), predict_bias(feat_d));
      end
    end
  end

  initial begin : stimulus
    logic [ResW-1:0] limits[Phases];
    longint r;
    feature_t f;
    limits = '{16'd1664, 16'd1, 16'hFFFF, 16'd0, 16'd16, 16'd800, 16'd3000, 16'd40000,
               16'd0, 16'd0};
    limits[8] = ResW'($urandom_range(2, 65534));
    limits[9] = ResW'($urandom_range(2, 65534));
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limit 1664: band edges, fix classes, saturation, run ends
    add_cell(0, 0, 1000, 1000, 1'b1, 1'b0);
    add_cell(0, 0, 100, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 2000, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 3000, 3000, 1'b1, 1'b0);
    add_cell(0, 0, 4000, 4000, 1'b1, 1'b0);
    add_cell(0, 0, 10000, 500, 1'b1, 1'b0);
    add_cell(0, 0, 3328, 3328, 1'b1, 1'b0);
    add_cell(0, 0, 3327, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 1664, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 2496, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 2495, 5000, 1'b1, 1'b0);
    add_cell(0, 0, 100, 100, 1'b0, 1'b0);
    add_cell(500, 0, -500, 2000, 1'b1, 1'b0);
    add_cell(MinC, MinC, MinC + 400, MinC + 400, 1'b1, 1'b0);
    add_cell(MaxC - 400, MaxC - 400, MaxC, MaxC, 1'b1, 1'b0);
    add_cell(MinC, 0, MaxC, 300, 1'b1, 1'b0);
    add_cell(MaxC, 0, MinC, 300, 1'b1, 1'b0);
    add_wire(0, 0, 1000, 50, 0, 1'b0);
    add_wire(0, 0, 1000, 50, 3327, 1'b0);
    add_wire(0, 0, 1000, 50, 3328, 1'b0);
    add_wire(0, 0, 1000, 50, 24'hFFFFFF, 1'b0);
    add_wire(2000, 900, -300, -100, 500, 1'b0);
    add_wire(MinC, MaxC - 40, MinC + 60, MaxC, 832, 1'b0);
    add_wire(-10, -10, 10, 10, 831, 1'b1);
    add_cell(0, 0, 5000, 5000, 1'b1, 1'b1);

    for (int p = 0; p < Phases; p++) begin
      wait_drained();
      steady = (p == 2 || p == 6);
      write_limit(limits[p]);
      r = (limits[p] == 0) ? 1 : longint'(limits[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        f = random_feature(r);
        if (i == PhaseItems - 1) f.last = 1'b1;
        feature_q.insert(feature_q.size(), f);
      end
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Checked %0d results over %0d limit settings (0, 1 and 65535 among them), %0d runs",
             results_seen, Phases + 1, n_run_ends);
    $display("Fix mix: none %0d, bias %0d, serif %0d, hammerhead %0d, wire %0d",
             fix_seen[0], fix_seen[1], fix_seen[2], fix_seen[3], fix_seen[4]);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #15ms;
    $error("timed out with %0d results outstanding", bias_expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/rbfb_pkg.sv
rtl/rule_based_feature_bias.sv
tb/rule_based_feature_bias_tb.sv
